// ===== rtl/mspi_pkg.sv =====
package mspi_pkg;

   // field widths
   localparam int ENC_W    = 16;
   localparam int TGT_W    = 15;
   localparam int SPEED_W  = 16;
   localparam int GAIN_W   = 8;
   localparam int LIMIT_W  = 15;
   localparam int PERIOD_W = 16;
   localparam int DUTY_W   = 7;
   localparam int CMP_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // internal datapath widths
   localparam int ERR_W   = 17;
   localparam int PROD_W  = 26;
   localparam int SUM_W   = 27;
   localparam int SCALE_W = 23;

   // divide by 100 through a reciprocal multiply, exact for values below 2**23
   localparam int DUTY_MAX  = 100;
   localparam int DIV_SHIFT = 30;
   localparam int RECIP_W   = 24;
   localparam logic [RECIP_W-1:0] DIV_RECIP =
      RECIP_W'(((2 ** DIV_SHIFT) + DUTY_MAX - 1) / DUTY_MAX);
   localparam int RPROD_W = SCALE_W + RECIP_W;

   localparam logic [ENC_W-1:0] SPEED_CENTER = 16'h7FFF;

   // default for the drive scaling shift
   localparam int OUTPUT_SHIFT_DEF = 5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_P_GAIN     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_I_GAIN     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INT_LIMIT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PWM_PERIOD = 2'd3;

   // register reset values
   localparam logic [GAIN_W-1:0]   P_GAIN_RST     = 8'd40;
   localparam logic [GAIN_W-1:0]   I_GAIN_RST     = 8'd15;
   localparam logic [LIMIT_W-1:0]  INT_LIMIT_RST  = 15'd3200;
   localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST = 16'd1200;

   typedef struct packed {
      logic [GAIN_W-1:0]   p_gain;
      logic [GAIN_W-1:0]   i_gain;
      logic [LIMIT_W-1:0]  integral_limit;
      logic [PERIOD_W-1:0] pwm_period;
   } cfg_type;

   // sequencer commands to the datapath
   typedef struct packed {
      logic accept;
      logic mul_en;
      logic int_en;
      logic drv_en;
      logic scale_en;
      logic load_out;
   } cmd_type;

endpackage

// ===== rtl/mspi_ctrl.sv =====
module mspi_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mspi_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_INT   = 3'd2;
   localparam logic [2:0] ST_DRV   = 3'd3;
   localparam logic [2:0] ST_SCALE = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   // output register can take a new result
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // step commands
   always_comb begin
      cmd          = '0;
      cmd.accept   = req_valid && (state_ff == ST_IDLE);
      cmd.mul_en   = (state_ff == ST_MUL);
      cmd.int_en   = (state_ff == ST_INT);
      cmd.drv_en   = (state_ff == ST_DRV);
      cmd.scale_en = (state_ff == ST_SCALE);
      cmd.load_out = (state_ff == ST_OUT) && out_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:   state_in = ST_INT;
         ST_INT:   state_in = ST_DRV;
         ST_DRV:   state_in = ST_SCALE;
         ST_SCALE: state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // result valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/mspi_dp.sv =====
module mspi_dp #(
   parameter int unsigned OUTPUT_SHIFT = mspi_pkg::OUTPUT_SHIFT_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  mspi_pkg::cmd_type                      cmd,
   input  mspi_pkg::cfg_type                      cfg,
   input  logic        [mspi_pkg::ENC_W-1:0]      req_encoder_count,
   input  logic signed [mspi_pkg::TGT_W-1:0]      req_target_speed,
   output logic        [mspi_pkg::DUTY_W-1:0]     rsp_duty_percent,
   output logic        [mspi_pkg::CMP_W-1:0]      rsp_compare_value,
   output logic signed [mspi_pkg::SPEED_W-1:0]    rsp_measured_speed,
   output logic signed [mspi_pkg::SPEED_W-1:0]    rsp_speed_error
);

   localparam int ERR_W   = mspi_pkg::ERR_W;
   localparam int PROD_W  = mspi_pkg::PROD_W;
   localparam int SUM_W   = mspi_pkg::SUM_W;
   localparam int SCALE_W = mspi_pkg::SCALE_W;
   localparam int RPROD_W = mspi_pkg::RPROD_W;

   logic signed [mspi_pkg::SPEED_W-1:0] speed_ff, speed_in;
   logic signed [ERR_W-1:0]             err_ff, err_in;
   logic signed [PROD_W-1:0]            prod_p_ff, prod_p_in;
   logic signed [PROD_W-1:0]            prod_i_ff, prod_i_in;
   logic        [mspi_pkg::LIMIT_W-1:0] integ_ff, integ_in;
   logic        [mspi_pkg::DUTY_W-1:0]  duty_ff, duty_in;
   logic        [SCALE_W-1:0]           scale_ff, scale_in;
   logic        [mspi_pkg::DUTY_W-1:0]  out_duty_ff, out_duty_in;
   logic        [mspi_pkg::CMP_W-1:0]   out_cmp_ff, out_cmp_in;
   logic signed [mspi_pkg::SPEED_W-1:0] out_speed_ff, out_speed_in;
   logic signed [mspi_pkg::SPEED_W-1:0] out_err_ff, out_err_in;

   logic signed [mspi_pkg::SPEED_W-1:0] speed_now;
   logic signed [ERR_W-1:0]             half_speed;
   logic signed [SUM_W-1:0]             int_sum;
   logic signed [SUM_W-1:0]             drv_sum;
   logic signed [SUM_W-1:0]             drv_shift;
   logic        [RPROD_W-1:0]           recip_prod;

   // speed and error from the request fields
   always_comb begin
      speed_now  = $signed(req_encoder_count - mspi_pkg::SPEED_CENTER);
      // halve, truncating toward zero
      half_speed = (ERR_W'(speed_now)
                    + ERR_W'($signed({1'b0, speed_now[mspi_pkg::SPEED_W-1]}))) >>> 1;
      speed_in   = cmd.accept ? speed_now : speed_ff;
      err_in     = cmd.accept ? (ERR_W'(req_target_speed) - half_speed) : err_ff;
   end

   // gain products
   always_comb begin
      prod_p_in = prod_p_ff;
      prod_i_in = prod_i_ff;
      if (cmd.mul_en) begin
         prod_p_in = PROD_W'($signed({1'b0, cfg.p_gain})) * PROD_W'(err_ff);
         prod_i_in = PROD_W'($signed({1'b0, cfg.i_gain})) * PROD_W'(err_ff);
      end
   end

   // integral update with clamp to 0..limit
   always_comb begin
      int_sum  = $signed(SUM_W'(integ_ff)) + SUM_W'(prod_i_ff);
      integ_in = integ_ff;
      if (cmd.int_en) begin
         if (int_sum[SUM_W-1]) begin
            integ_in = '0;
         end else if (int_sum > $signed(SUM_W'(cfg.integral_limit))) begin
            integ_in = cfg.integral_limit;
         end else begin
            integ_in = int_sum[mspi_pkg::LIMIT_W-1:0];
         end
      end
   end

   // drive, floor shift, clamp to 0..100
   always_comb begin
      drv_sum   = SUM_W'(prod_p_ff) + $signed(SUM_W'(integ_ff));
      drv_shift = drv_sum >>> OUTPUT_SHIFT;
      duty_in   = duty_ff;
      if (cmd.drv_en) begin
         if (drv_shift[SUM_W-1]) begin
            duty_in = '0;
         end else if (drv_shift > $signed(SUM_W'(mspi_pkg::DUTY_MAX))) begin
            duty_in = mspi_pkg::DUTY_W'(mspi_pkg::DUTY_MAX);
         end else begin
            duty_in = drv_shift[mspi_pkg::DUTY_W-1:0];
         end
      end
   end

   // duty times period
   always_comb begin
      scale_in = scale_ff;
      if (cmd.scale_en) begin
         scale_in = SCALE_W'(duty_ff) * SCALE_W'(cfg.pwm_period);
      end
   end

   // divide by 100 and load the output register
   always_comb begin
      recip_prod   = RPROD_W'(scale_ff) * RPROD_W'(mspi_pkg::DIV_RECIP);
      out_duty_in  = out_duty_ff;
      out_cmp_in   = out_cmp_ff;
      out_speed_in = out_speed_ff;
      out_err_in   = out_err_ff;
      if (cmd.load_out) begin
         out_duty_in  = duty_ff;
         out_cmp_in   = recip_prod[mspi_pkg::DIV_SHIFT +: mspi_pkg::CMP_W];
         out_speed_in = speed_ff;
         out_err_in   = err_ff[mspi_pkg::SPEED_W-1:0];
      end
   end

   // integral state
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
      end else begin
         integ_ff <= integ_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      speed_ff     <= speed_in;
      err_ff       <= err_in;
      prod_p_ff    <= prod_p_in;
      prod_i_ff    <= prod_i_in;
      duty_ff      <= duty_in;
      scale_ff     <= scale_in;
      out_duty_ff  <= out_duty_in;
      out_cmp_ff   <= out_cmp_in;
      out_speed_ff <= out_speed_in;
      out_err_ff   <= out_err_in;
   end

   assign rsp_duty_percent   = out_duty_ff;
   assign rsp_compare_value  = out_cmp_ff;
   assign rsp_measured_speed = out_speed_ff;
   assign rsp_speed_error    = out_err_ff;

endmodule

// ===== rtl/motor_speed_pi_controller_top.sv =====
// Motor speed PI controller. Each request is one control tick: the encoder count
// (centered at 0x7FFF) and a target speed in units of two counts per tick. The response
// carries the measured speed, the speed error, the duty cycle in percent (PI drive
// with the integral clamped to 0..integral_limit, scaled down by OUTPUT_SHIFT and
// clamped to 0..100) and the PWM compare value duty*pwm_period/100. A request is
// accepted only when the sequencer is idle; the sequencer then steps through gain
// multiply, integral clamp, drive clamp, period multiply and divide-by-100, and
// takes no new request before it is back in idle. A finished response waits in its
// own output register, so the next request can be accepted and worked on while it
// is held; the sequencer only stalls in its last step if the previous response has
// still not been taken. Registers are written through the csr port and should only
// change while no request is in work.
module motor_speed_pi_controller_top #(
   parameter int unsigned OUTPUT_SHIFT = mspi_pkg::OUTPUT_SHIFT_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic        [mspi_pkg::ENC_W-1:0]        req_encoder_count,
   input  logic signed [mspi_pkg::TGT_W-1:0]        req_target_speed,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic        [mspi_pkg::DUTY_W-1:0]       rsp_duty_percent,
   output logic        [mspi_pkg::CMP_W-1:0]        rsp_compare_value,
   output logic signed [mspi_pkg::SPEED_W-1:0]      rsp_measured_speed,
   output logic signed [mspi_pkg::SPEED_W-1:0]      rsp_speed_error,
   input  logic                                     csr_wr_en,
   input  logic        [mspi_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic        [mspi_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   mspi_pkg::cfg_type cfg_ff;
   mspi_pkg::cfg_type cfg_in;
   mspi_pkg::cmd_type cmd;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            mspi_pkg::REG_P_GAIN:     cfg_in.p_gain = csr_wdata[mspi_pkg::GAIN_W-1:0];
            mspi_pkg::REG_I_GAIN:     cfg_in.i_gain = csr_wdata[mspi_pkg::GAIN_W-1:0];
            mspi_pkg::REG_INT_LIMIT:
               cfg_in.integral_limit = csr_wdata[mspi_pkg::LIMIT_W-1:0];
            mspi_pkg::REG_PWM_PERIOD:
               cfg_in.pwm_period = csr_wdata[mspi_pkg::PERIOD_W-1:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.p_gain         <= mspi_pkg::P_GAIN_RST;
         cfg_ff.i_gain         <= mspi_pkg::I_GAIN_RST;
         cfg_ff.integral_limit <= mspi_pkg::INT_LIMIT_RST;
         cfg_ff.pwm_period     <= mspi_pkg::PWM_PERIOD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer
   mspi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // arithmetic
   mspi_dp #(
      .OUTPUT_SHIFT (OUTPUT_SHIFT)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .cfg                (cfg_ff),
      .req_encoder_count  (req_encoder_count),
      .req_target_speed   (req_target_speed),
      .rsp_duty_percent   (rsp_duty_percent),
      .rsp_compare_value  (rsp_compare_value),
      .rsp_measured_speed (rsp_measured_speed),
      .rsp_speed_error    (rsp_speed_error)
   );

endmodule
